/* hw/rtl/tksd_pkg.sv */
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared constants for the terminal key sequence decoder: item kinds,
// key codes, parser phases and the byte values the parser recognizes.
// ----------------------------------------------------------------------------
package tksd_pkg;

	localparam int TIMEOUT_BITS = 16;
	localparam int CFG_W        = 16;
	localparam int CMP_W        = (TIMEOUT_BITS > CFG_W) ? TIMEOUT_BITS : CFG_W;

	typedef logic [TIMEOUT_BITS-1:0] wait_t;
	typedef logic [CFG_W-1:0]        timeout_t;
	typedef logic [CMP_W-1:0]        cmp_t;
	typedef logic [3:0]              key_t;
	typedef logic [1:0]              func_t;
	typedef logic [2:0]              phase_t;

	localparam func_t F_BYTE   = 2'd0;
	localparam func_t F_TICK   = 2'd1;
	localparam func_t F_RESIZE = 2'd2;

	localparam phase_t PH_IDLE  = 3'd0;
	localparam phase_t PH_ESC   = 3'd1;
	localparam phase_t PH_INTRO = 3'd2;
	localparam phase_t PH_DIGIT = 3'd3;
	localparam phase_t PH_MOUSE = 3'd4;

	localparam key_t K_CHAR   = 4'd0;
	localparam key_t K_ENTER  = 4'd1;
	localparam key_t K_BKSP   = 4'd2;
	localparam key_t K_ESC    = 4'd3;
	localparam key_t K_UP     = 4'd4;
	localparam key_t K_DOWN   = 4'd5;
	localparam key_t K_RIGHT  = 4'd6;
	localparam key_t K_LEFT   = 4'd7;
	localparam key_t K_HOME   = 4'd8;
	localparam key_t K_END    = 4'd9;
	localparam key_t K_PGUP   = 4'd10;
	localparam key_t K_PGDN   = 4'd11;
	localparam key_t K_WHUP   = 4'd12;
	localparam key_t K_WHDN   = 4'd13;
	localparam key_t K_NONE   = 4'd14;
	localparam key_t K_WINCH  = 4'd15;

	localparam logic [1:0] MS_SKIP = 2'd0;
	localparam logic [1:0] MS_SIGN = 2'd1;
	localparam logic [1:0] MS_DIG  = 2'd2;
	localparam logic [1:0] MS_DONE = 2'd3;

	localparam logic [7:0] B_BS    = 8'h08;
	localparam logic [7:0] B_TAB   = 8'h09;
	localparam logic [7:0] B_LF    = 8'h0a;
	localparam logic [7:0] B_CR    = 8'h0d;
	localparam logic [7:0] B_ESC   = 8'h1b;
	localparam logic [7:0] B_SPACE = 8'h20;
	localparam logic [7:0] B_PLUS  = 8'h2b;
	localparam logic [7:0] B_ZERO  = 8'h30;
	localparam logic [7:0] B_ONE   = 8'h31;
	localparam logic [7:0] B_FOUR  = 8'h34;
	localparam logic [7:0] B_FIVE  = 8'h35;
	localparam logic [7:0] B_SIX   = 8'h36;
	localparam logic [7:0] B_NINE  = 8'h39;
	localparam logic [7:0] B_LT    = 8'h3c;
	localparam logic [7:0] B_A     = 8'h41;
	localparam logic [7:0] B_B     = 8'h42;
	localparam logic [7:0] B_C     = 8'h43;
	localparam logic [7:0] B_D     = 8'h44;
	localparam logic [7:0] B_F     = 8'h46;
	localparam logic [7:0] B_H     = 8'h48;
	localparam logic [7:0] B_UM    = 8'h4d;
	localparam logic [7:0] B_O     = 8'h4f;
	localparam logic [7:0] B_LBRK  = 8'h5b;
	localparam logic [7:0] B_LM    = 8'h6d;
	localparam logic [7:0] B_TILDE = 8'h7e;
	localparam logic [7:0] B_DEL   = 8'h7f;

	localparam logic [6:0] MOUSE_MAX  = 7'd127;
	localparam logic [6:0] MOUSE_WHUP = 7'd64;
	localparam logic [6:0] MOUSE_WHDN = 7'd65;

	localparam timeout_t TIMEOUT_RESET = 16'd20;

endpackage

/* hw/rtl/terminal_key_sequence_decoder.sv */
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Input words pass an input register and then a result register. Throughput:
// one word per cycle while the result side is not stalled by m_tready.
// Reset: asynchronous, active low; parser returns to idle, timeout is 20.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  tksd_pkg::func_t       s_tuser,   // [1:0] func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] char_value
	output tksd_pkg::key_t        m_tuser,   // [3:0] key_code
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  tksd_pkg::timeout_t    cfg_data
);
	import tksd_pkg::*;

	logic       in_valid_s1;
	func_t      in_func_s1;
	logic [7:0] in_byte_s1;
	logic       advance;

	timeout_t   timeout_q;
	phase_t     phase_q, phase_d;
	wait_t      wait_q, wait_d;
	logic [7:0] held_q, held_d;
	logic [6:0] mnum_q, mnum_d;
	logic [1:0] mflag_q, mflag_d;

	logic       emit;
	key_t       key;
	logic [7:0] chr;

	logic       out_valid_q;
	key_t       out_key_q;
	logic [7:0] out_chr_q;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !in_valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_func_s1 <= s_tuser;
			in_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	logic       is_dig;
	logic       is_sp;
	logic [10:0] mprod;
	wait_t      wait_inc;
	cmp_t       lim;

	always_comb begin
		is_dig   = (in_byte_s1 >= B_ZERO) && (in_byte_s1 <= B_NINE);
		is_sp    = (in_byte_s1 == B_SPACE) || ((in_byte_s1 >= B_TAB) && (in_byte_s1 <= B_CR));
		mprod    = {1'b0, mnum_q, 3'b000} + {3'b000, mnum_q, 1'b0}
			+ {7'd0, 4'(in_byte_s1 - B_ZERO)};
		wait_inc = (wait_q == {TIMEOUT_BITS{1'b1}}) ? wait_q : wait_q + 1'b1;
		lim      = (timeout_q == '0) ? cmp_t'(1) : cmp_t'(timeout_q);

		phase_d = phase_q;
		wait_d  = wait_q;
		held_d  = held_q;
		mnum_d  = mnum_q;
		mflag_d = mflag_q;
		emit    = 1'b0;
		key     = K_NONE;
		chr     = 8'd0;

		unique case (in_func_s1)
			F_TICK: begin
				if (phase_q == PH_ESC) begin
					wait_d = wait_inc;
					if (cmp_t'(wait_inc) >= lim || wait_inc == {TIMEOUT_BITS{1'b1}}) begin
						emit = 1'b1;
						key  = K_ESC;
					end
				end
			end
			F_RESIZE: begin
				if (phase_q == PH_IDLE) begin
					emit = 1'b1;
					key  = K_WINCH;
				end
			end
			F_BYTE: begin
				unique case (phase_q)
					PH_IDLE: begin
						if (in_byte_s1 == B_CR || in_byte_s1 == B_LF) begin
							emit = 1'b1;
							key  = K_ENTER;
						end else if (in_byte_s1 == B_DEL || in_byte_s1 == B_BS) begin
							emit = 1'b1;
							key  = K_BKSP;
						end else if (in_byte_s1 == B_ESC) begin
							phase_d = PH_ESC;
							wait_d  = '0;
						end else begin
							emit = 1'b1;
							key  = K_CHAR;
							chr  = in_byte_s1;
						end
					end
					PH_ESC: begin
						if (in_byte_s1 == B_LBRK || in_byte_s1 == B_O) begin
							held_d  = in_byte_s1;
							phase_d = PH_INTRO;
						end else begin
							emit = 1'b1;
							key  = K_ESC;
						end
					end
					PH_INTRO: begin
						if (held_q == B_LBRK && in_byte_s1 == B_LT) begin
							mnum_d  = '0;
							mflag_d = MS_SKIP;
							phase_d = PH_MOUSE;
						end else if (is_dig) begin
							held_d  = in_byte_s1;
							phase_d = PH_DIGIT;
						end else begin
							emit = 1'b1;
							unique case (in_byte_s1)
								B_A:     key = K_UP;
								B_B:     key = K_DOWN;
								B_C:     key = K_RIGHT;
								B_D:     key = K_LEFT;
								B_H:     key = K_HOME;
								B_F:     key = K_END;
								default: key = K_ESC;
							endcase
						end
					end
					PH_DIGIT: begin
						emit = 1'b1;
						if (in_byte_s1 != B_TILDE) begin
							key = K_ESC;
						end else begin
							unique case (held_q)
								B_ONE:   key = K_HOME;
								B_FOUR:  key = K_END;
								B_FIVE:  key = K_PGUP;
								B_SIX:   key = K_PGDN;
								default: key = K_ESC;
							endcase
						end
					end
					PH_MOUSE: begin
						if (in_byte_s1 == B_UM || in_byte_s1 == B_LM) begin
							emit = 1'b1;
							if (mnum_q == MOUSE_WHUP) begin
								key = K_WHUP;
							end else if (mnum_q == MOUSE_WHDN) begin
								key = K_WHDN;
							end else begin
								key = K_NONE;
							end
						end else if (mflag_q != MS_DONE) begin
							if (is_dig) begin
								mnum_d  = (mprod > 11'(MOUSE_MAX)) ? MOUSE_MAX : mprod[6:0];
								mflag_d = MS_DIG;
							end else if (mflag_q == MS_SKIP) begin
								if (in_byte_s1 == B_PLUS) begin
									mflag_d = MS_SIGN;
								end else if (!is_sp) begin
									mnum_d  = '0;
									mflag_d = MS_DONE;
								end
							end else begin
								mflag_d = MS_DONE;
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase

		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			held_q  <= '0;
			mnum_q  <= '0;
			mflag_q <= MS_SKIP;
		end else if (in_valid_s1 && advance) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			held_q  <= held_d;
			mnum_q  <= mnum_d;
			mflag_q <= mflag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1 && emit) begin
			out_key_q <= key;
			out_chr_q <= chr;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_key_q;
	assign m_tdata  = out_chr_q;

	a_char_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != K_CHAR |-> m_tdata == 8'd0)
		else $error("nonzero character on a non-character key");

	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && advance && in_func_s1 == F_TICK && phase_q != PH_ESC |=> !m_tvalid)
		else $error("tick outside escape wait produced a key");

	a_resize_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && advance && in_func_s1 == F_RESIZE && phase_q != PH_IDLE |=> !m_tvalid)
		else $error("resize reported outside idle");

	a_esc_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && advance && in_func_s1 == F_BYTE && phase_q == PH_IDLE
		&& in_byte_s1 == B_ESC |=> phase_q == PH_ESC && wait_q == '0)
		else $error("escape did not start the wait");

endmodule

/* sim/tb_terminal_key_sequence_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_key_sequence_decoder
// Feeds bytes, timer ticks and resize events into the key decoder. A built-in
// predictor tracks the parser phase, the escape wait, the held introducer or
// digit and the mouse button number, and the monitor checks every decoded key
// word in order. Directed sequences come first, then phases of random escape,
// cursor, paging and mouse sequences mixed with noise under several timeout
// settings, with random idling on both stream sides except in one calm phase.
// ----------------------------------------------------------------------------
module tb_terminal_key_sequence_decoder;
	import tksd_pkg::*;

	localparam int         IDLE_PCT    = 29;
	localparam int         LAT_CYCLES  = 4;
	localparam int         DRAIN_LIMIT = 400;
	localparam int         STALL_LIMIT = 2000;
	localparam func_t      F_SPARE     = 2'd3;
	localparam logic [7:0] B_MINUS     = 8'h2d;
	localparam logic [7:0] B_SEMI      = 8'h3b;

	typedef struct packed {
		func_t      func;
		logic [7:0] rx_byte;
	} keystroke_t;

	typedef struct packed {
		key_t       code;
		logic [7:0] char_value;
	} decoded_key_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     s_tvalid  = 1'b0;
	logic     s_tready;
	logic [7:0] s_tdata = 8'h00;
	func_t    s_tuser   = F_BYTE;
	logic     m_tvalid;
	logic     m_tready  = 1'b0;
	logic [7:0] m_tdata;
	key_t     m_tuser;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	timeout_t cfg_data  = '0;

	keystroke_t   keystroke_queue[$];
	decoded_key_t expected_keys[$];
	int           pushed       = 0;
	int           errors       = 0;
	int           stall_cycles = 0;
	bit           word_held    = 1'b0;
	bit           in_taken     = 1'b0;
	bit           cfg_seen     = 1'b0;
	bit           calm         = 1'b0;

	phase_t     phase_q     = PH_IDLE;
	wait_t      tick_count  = '0;
	logic [7:0] held_byte   = 8'h00;
	logic [6:0] button_num  = '0;
	logic [1:0] num_state   = MS_SKIP;
	timeout_t   timeout_val = TIMEOUT_RESET;

	terminal_key_sequence_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic emit_key(input key_t k, input logic [7:0] c);
		expected_keys.push_back('{code: k, char_value: (k == K_CHAR) ? c : 8'h00});
		phase_q = PH_IDLE;
	endtask

	task automatic decode_keystroke(input func_t f, input logic [7:0] b);
		cmp_t limit;
		int   sum;
		if (f == F_TICK) begin
			if (phase_q == PH_ESC) begin
				limit = (timeout_val == '0) ? cmp_t'(1) : cmp_t'(timeout_val);
				if (tick_count != '1)
					tick_count = tick_count + 1'b1;
				if (cmp_t'(tick_count) >= limit || tick_count == '1)
					emit_key(K_ESC, 8'h00);
			end
		end else if (f == F_RESIZE) begin
			if (phase_q == PH_IDLE)
				emit_key(K_WINCH, 8'h00);
		end else if (f == F_BYTE) begin
			case (phase_q)
				PH_IDLE: begin
					if (b == B_CR || b == B_LF)
						emit_key(K_ENTER, 8'h00);
					else if (b == B_DEL || b == B_BS)
						emit_key(K_BKSP, 8'h00);
					else if (b == B_ESC) begin
						phase_q    = PH_ESC;
						tick_count = '0;
					end else
						emit_key(K_CHAR, b);
				end
				PH_ESC: begin
					if (b == B_LBRK || b == B_O) begin
						held_byte = b;
						phase_q   = PH_INTRO;
					end else
						emit_key(K_ESC, 8'h00);
				end
				PH_INTRO: begin
					if (held_byte == B_LBRK && b == B_LT) begin
						button_num = '0;
						num_state  = MS_SKIP;
						phase_q    = PH_MOUSE;
					end else if (b >= B_ZERO && b <= B_NINE) begin
						held_byte = b;
						phase_q   = PH_DIGIT;
					end else begin
						case (b)
							B_A:     emit_key(K_UP, 8'h00);
							B_B:     emit_key(K_DOWN, 8'h00);
							B_C:     emit_key(K_RIGHT, 8'h00);
							B_D:     emit_key(K_LEFT, 8'h00);
							B_H:     emit_key(K_HOME, 8'h00);
							B_F:     emit_key(K_END, 8'h00);
							default: emit_key(K_ESC, 8'h00);
						endcase
					end
				end
				PH_DIGIT: begin
					if (b != B_TILDE)
						emit_key(K_ESC, 8'h00);
					else begin
						case (held_byte)
							B_ONE:   emit_key(K_HOME, 8'h00);
							B_FOUR:  emit_key(K_END, 8'h00);
							B_FIVE:  emit_key(K_PGUP, 8'h00);
							B_SIX:   emit_key(K_PGDN, 8'h00);
							default: emit_key(K_ESC, 8'h00);
						endcase
					end
				end
				PH_MOUSE: begin
					if (b == B_UM || b == B_LM) begin
						if (button_num == MOUSE_WHUP)
							emit_key(K_WHUP, 8'h00);
						else if (button_num == MOUSE_WHDN)
							emit_key(K_WHDN, 8'h00);
						else
							emit_key(K_NONE, 8'h00);
					end else if (num_state != MS_DONE) begin
						if (b >= B_ZERO && b <= B_NINE) begin
							sum        = int'(button_num) * 10 + int'(b) - int'(B_ZERO);
							button_num = (sum > int'(MOUSE_MAX)) ? MOUSE_MAX : sum[6:0];
							num_state  = MS_DIG;
						end else if (num_state == MS_SKIP && b == B_PLUS)
							num_state = MS_SIGN;
						else if (!(num_state == MS_SKIP &&
								(b == B_SPACE || (b >= B_TAB && b <= B_CR)))) begin
							if (num_state == MS_SKIP)
								button_num = '0;
							num_state = MS_DONE;
						end
					end
				end
				default: phase_q = PH_IDLE;
			endcase
		end
	endtask

	// Monitor: sample handshakes, predict accepted words, check decoded keys.
	always @(posedge clk) begin
		decoded_key_t want;
		bit           out_taken;
		if (arst_n) begin
			in_taken  = s_tvalid && s_tready;
			cfg_seen  = cfg_valid && cfg_ready;
			out_taken = m_tvalid && m_tready;
			if (cfg_seen)
				timeout_val = cfg_data;
			if (in_taken)
				decode_keystroke(s_tuser, s_tdata);
			if (out_taken) begin
				if (expected_keys.size() == 0)
					flag_error($sformatf("unexpected key %0d char %02h", m_tuser, m_tdata));
				else begin
					want = expected_keys.pop_front();
					if (m_tuser !== want.code)
						flag_error($sformatf("key_code %0d, want %0d", m_tuser, want.code));
					if (m_tdata !== want.char_value)
						flag_error($sformatf("char_value %02h, want %02h",
							m_tdata, want.char_value));
				end
			end
			stall_cycles = (in_taken || cfg_seen || out_taken) ? 0 : stall_cycles + 1;
		end
	end

	// Driver: hold a word until taken, then advance or idle.
	always @(negedge clk) begin
		keystroke_t next_word;
		if (arst_n) begin
			if (in_taken)
				word_held = 1'b0;
			if (!word_held && keystroke_queue.size() != 0 &&
					(calm || $urandom_range(99) >= IDLE_PCT)) begin
				next_word = keystroke_queue.pop_front();
				word_held = 1'b1;
				s_tdata  <= next_word.rx_byte;
				s_tuser  <= next_word.func;
			end
			s_tvalid <= word_held;
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("tb_terminal_key_sequence_decoder NOT OK");
		$finish;
	end

	task automatic push_key(input func_t f, input logic [7:0] b);
		keystroke_queue.push_back('{func: f, rx_byte: b});
		pushed++;
	endtask

	// ESC, then one tick short of the limit, an ignored resize, the final tick
	// and a resize that only counts once the parser is back in idle.
	task automatic add_timeout_check(input int unsigned limit);
		push_key(F_BYTE, B_ESC);
		repeat ((limit > 1) ? limit - 1 : 0)
			push_key(F_TICK, 8'($urandom_range(255)));
		push_key(F_RESIZE, 8'($urandom_range(255)));
		push_key(F_TICK, 8'($urandom_range(255)));
		push_key(F_RESIZE, 8'($urandom_range(255)));
	endtask

	task automatic write_timeout(input timeout_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(negedge clk);
		while (!cfg_seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		while (keystroke_queue.size() != 0 || word_held)
			@(negedge clk);
		while (expected_keys.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_keys.size() != 0) begin
			flag_error($sformatf("%0d keys never arrived", expected_keys.size()));
			expected_keys.delete();
		end
		repeat (LAT_CYCLES)
			@(negedge clk);
	endtask

	task automatic add_random_keys(input int count, input timeout_t setting);
		int         target, kind, reach, val, sign;
		string      digits;
		logic [7:0] finals [6];
		logic [7:0] paging [4];
		target = pushed + count;
		finals = '{B_A, B_B, B_C, B_D, B_H, B_F};
		paging = '{B_ONE, B_FOUR, B_FIVE, B_SIX};
		reach  = (setting > 8) ? 8 : ((setting == 0) ? 1 : int'(setting)) + 2;
		while (pushed < target) begin
			kind = $urandom_range(99);
			if (kind < 12)
				push_key(func_t'($urandom_range(3)), 8'($urandom_range(255)));
			else if (kind < 22)
				push_key(F_BYTE, 8'($urandom_range(255)));
			else if (kind < 40) begin
				push_key(F_BYTE, B_ESC);
				push_key(F_BYTE, ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
					($urandom_range(1) ? B_LBRK : B_O));
				push_key(F_BYTE, ($urandom_range(4) != 0) ? finals[$urandom_range(5)] :
					8'($urandom_range(255)));
			end else if (kind < 55) begin
				push_key(F_BYTE, B_ESC);
				push_key(F_BYTE, ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
					($urandom_range(1) ? B_LBRK : B_O));
				push_key(F_BYTE, ($urandom_range(9) < 7) ? paging[$urandom_range(3)] :
					8'($urandom_range(B_ZERO, B_NINE)));
				push_key(F_BYTE, ($urandom_range(4) != 0) ? B_TILDE : 8'($urandom_range(255)));
			end else if (kind < 80) begin
				push_key(F_BYTE, B_ESC);
				push_key(F_BYTE, ($urandom_range(9) == 0) ? B_O : B_LBRK);
				push_key(F_BYTE, B_LT);
				repeat ($urandom_range(2))
					push_key(F_BYTE, ($urandom_range(5) == 0) ? B_SPACE :
						8'($urandom_range(B_TAB, B_CR)));
				sign = $urandom_range(9);
				if (sign < 2)
					push_key(F_BYTE, B_PLUS);
				else if (sign == 2)
					push_key(F_BYTE, B_MINUS);
				case ($urandom_range(5))
					0:       val = int'(MOUSE_WHUP);
					1:       val = int'(MOUSE_WHDN);
					2:       val = $urandom_range(127);
					3:       val = $urandom_range(128, 99999);
					4:       val = 63 + 3 * $urandom_range(1);
					default: val = -1;
				endcase
				if (val >= 0) begin
					digits = $sformatf("%0d", val);
					if ($urandom_range(3) == 0)
						digits = {"0", digits};
					for (int i = 0; i < digits.len(); i++)
						push_key(F_BYTE, digits[i]);
				end
				repeat ($urandom_range(3)) begin
					sign = $urandom_range(9);
					if (sign < 5)
						push_key(F_BYTE, B_SEMI);
					else if (sign < 8)
						push_key(F_BYTE, 8'($urandom_range(B_ZERO, B_NINE)));
					else if (sign == 8)
						push_key(F_TICK, 8'($urandom_range(255)));
					else
						push_key(F_BYTE, 8'($urandom_range(255)));
				end
				push_key(F_BYTE, $urandom_range(1) ? B_UM : B_LM);
			end else if (kind < 92) begin
				push_key(F_BYTE, B_ESC);
				repeat ($urandom_range(reach))
					push_key(F_TICK, 8'($urandom_range(255)));
				if ($urandom_range(1))
					push_key(F_BYTE, 8'($urandom_range(255)));
			end else begin
				push_key(F_BYTE, B_ESC);
				push_key(F_RESIZE, 8'($urandom_range(255)));
				push_key(F_TICK, 8'($urandom_range(255)));
				push_key(F_BYTE, B_LBRK);
				push_key(F_BYTE, B_B);
			end
		end
	endtask

	initial begin
		timeout_t settings [5];
		settings = '{16'd0, 16'd1, 16'hffff, timeout_t'(2 + $urandom_range(4)), 16'd3};
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;

		push_key(F_BYTE, 8'h00);
		push_key(F_BYTE, 8'hff);
		push_key(F_BYTE, B_CR);
		push_key(F_BYTE, B_LF);
		push_key(F_BYTE, B_DEL);
		push_key(F_BYTE, B_BS);
		push_key(F_RESIZE, 8'h00);
		push_key(F_SPARE, 8'hff);
		push_key(F_TICK, 8'h00);
		push_key(F_BYTE, B_ESC);
		push_key(F_RESIZE, 8'h00);
		push_key(F_BYTE, 8'h78);
		push_key(F_BYTE, B_ESC);
		push_key(F_BYTE, B_LBRK);
		push_key(F_BYTE, B_A);
		push_key(F_BYTE, B_ESC);
		push_key(F_BYTE, B_O);
		push_key(F_BYTE, B_LT);
		push_key(F_BYTE, B_ESC);
		push_key(F_BYTE, B_LBRK);
		push_key(F_BYTE, B_FIVE);
		push_key(F_BYTE, B_TILDE);
		push_key(F_BYTE, B_ESC);
		push_key(F_BYTE, B_LBRK);
		push_key(F_BYTE, B_LT);
		push_key(F_BYTE, B_SPACE);
		push_key(F_BYTE, B_PLUS);
		push_key(F_BYTE, B_SIX);
		push_key(F_BYTE, B_FOUR);
		push_key(F_BYTE, B_SEMI);
		push_key(F_BYTE, B_UM);
		add_timeout_check(TIMEOUT_RESET);
		settle();

		for (int i = 0; i < 5; i++) begin
			calm = (i == 1);
			write_timeout(settings[i]);
			if (settings[i] != '1)
				add_timeout_check(settings[i]);
			add_random_keys(90, settings[i]);
			settle();
		end

		if (errors == 0)
			$display("tb_terminal_key_sequence_decoder OK");
		else
			$display("tb_terminal_key_sequence_decoder NOT OK");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/tksd_pkg.sv
hw/rtl/terminal_key_sequence_decoder.sv
sim/tb_terminal_key_sequence_decoder.sv
